// ===== rtl/fir_er_pkg.sv =====
// Shared types and constants for the edge-replicating FIR filter.
`timescale 1ns / 1ps
package fir_er_pkg;

    localparam int MAX_TAPS_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int IDX_W          = 5;
    localparam int TC_W           = 6;
    localparam int CNT_W          = 9;
    localparam int OUT_W          = 37;
    localparam int OUT_TDATA_W    = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        KIND_LOAD = 1'b0,
        KIND_PUSH = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic [CNT_W-1:0]   cnt;
    } t_cmd;

endpackage

// ===== rtl/fir_er_fifo.sv =====
// Two-entry request queue between the front and back parts.
`timescale 1ns / 1ps
module fir_er_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             c_push;
    logic             c_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign c_push  = i_valid && o_ready;
    assign c_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (c_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (c_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({c_push, c_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/fir_er_front.sv =====
// Front part: accepts input requests, drops bad loads, sizes sample pushes.
`timescale 1ns / 1ps
module fir_er_front #(
    parameter int MAX_TAPS   = fir_er_pkg::MAX_TAPS_DEF,
    parameter int DATA_WIDTH = fir_er_pkg::DATA_WIDTH_DEF,
    parameter int WW         = $clog2(MAX_TAPS + 1),
    parameter int IN_TDATA_W = ((fir_er_pkg::IDX_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [WW-1:0]         i_w,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  s_axis_tlast,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_ready,
    output fir_er_pkg::t_cmd      o_cmd,
    output logic [DATA_WIDTH-1:0] o_cmd_value
);
    import fir_er_pkg::*;

    logic             r_mid;
    logic             c_push_kind;
    logic             c_keep;
    logic [WW-1:0]    c_half;
    logic [CNT_W-1:0] c_base;
    logic [CNT_W-1:0] c_cnt;
    logic [IDX_W-1:0] c_idx;

    assign c_idx       = s_axis_tdata[IDX_W-1:0];
    assign c_push_kind = (t_kind'(s_axis_tuser) == KIND_PUSH);
    assign c_keep      = c_push_kind || (32'(c_idx) < MAX_TAPS);
    assign c_half      = i_w >> 1;
    assign c_base      = r_mid ? CNT_W'(1) : CNT_W'(c_half) + CNT_W'(1);
    assign c_cnt       = s_axis_tlast ? c_base + CNT_W'(c_half) : c_base;

    assign s_axis_tready = i_cmd_ready;
    assign o_cmd_valid   = s_axis_tvalid && c_keep;
    assign o_cmd_value   = s_axis_tdata[IDX_W +: DATA_WIDTH];

    always_comb begin
        o_cmd.kind = c_push_kind ? KIND_PUSH : KIND_LOAD;
        o_cmd.idx  = c_idx;
        o_cmd.last = s_axis_tlast;
        o_cmd.cnt  = c_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready && c_push_kind) begin
            r_mid <= !s_axis_tlast;
        end
    end

endmodule

// ===== rtl/fir_er_back.sv =====
// Back part: tap memory, circular delay line and one shared multiply-accumulate.
`timescale 1ns / 1ps
module fir_er_back #(
    parameter int MAX_TAPS   = fir_er_pkg::MAX_TAPS_DEF,
    parameter int DATA_WIDTH = fir_er_pkg::DATA_WIDTH_DEF,
    parameter int WW         = $clog2(MAX_TAPS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [WW-1:0]                i_w,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  fir_er_pkg::t_cmd             i_cmd,
    input  logic [DATA_WIDTH-1:0]        i_cmd_value,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [fir_er_pkg::OUT_W-1:0] o_m_data,
    output logic                         o_m_last
);
    import fir_er_pkg::*;

    localparam int PW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int DEPTH = 1 << PW;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PUSH,
        B_MAC,
        B_DRAIN,
        B_OUT
    } t_bstate;

    t_bstate                        r_state;
    logic [DATA_WIDTH-1:0]          r_tap_mem [DEPTH];
    logic [DATA_WIDTH-1:0]          r_dl_mem  [DEPTH];
    logic signed [DATA_WIDTH-1:0]   r_tap_q;
    logic signed [DATA_WIDTH-1:0]   r_dl_q;
    logic signed [2*DATA_WIDTH-1:0] r_prod;
    logic [OUT_W-1:0]               r_acc;
    logic [PW-1:0]                  r_wp;
    logic [WW-1:0]                  r_fill;
    logic [WW-1:0]                  r_j;
    logic [CNT_W-1:0]               r_left;
    logic [DATA_WIDTH-1:0]          r_val;
    logic                           r_last;
    logic                           r_rd_v;
    logic                           r_mul_v;
    logic                           r_out_valid;
    logic [OUT_W-1:0]               r_out_data;
    logic                           r_out_last;
    logic [WW-1:0]                  c_fill_next;
    logic [PW-1:0]                  c_dl_addr;
    logic                           c_tap_we;

    assign o_cmd_ready = (r_state == B_IDLE);
    assign o_m_valid   = r_out_valid;
    assign o_m_data    = r_out_data;
    assign o_m_last    = r_out_last;

    assign c_fill_next = (r_fill == WW'(MAX_TAPS)) ? r_fill : r_fill + WW'(1);
    assign c_dl_addr   = r_wp + PW'(r_j) - PW'(i_w);
    assign c_tap_we    = (r_state == B_IDLE) && i_cmd_valid && (i_cmd.kind == KIND_LOAD);

    always_ff @(posedge i_clk) begin
        if (c_tap_we) begin
            r_tap_mem[PW'(i_cmd.idx)] <= i_cmd_value;
        end
        r_tap_q <= r_tap_mem[PW'(r_j)];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_PUSH) begin
            r_dl_mem[r_wp] <= r_val;
        end
        r_dl_q <= r_dl_mem[c_dl_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v  <= 1'b0;
            r_mul_v <= r_rd_v;
            if (r_rd_v) begin
                r_prod <= r_tap_q * r_dl_q;
            end
            if (r_mul_v) begin
                r_acc <= r_acc + OUT_W'(r_prod);
            end
            if (r_out_valid && i_m_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid && (i_cmd.kind == KIND_PUSH)) begin
                        r_val   <= i_cmd_value;
                        r_last  <= i_cmd.last;
                        r_left  <= i_cmd.cnt;
                        r_state <= B_PUSH;
                    end
                end
                B_PUSH: begin
                    r_wp   <= r_wp + PW'(1);
                    r_fill <= c_fill_next;
                    r_left <= r_left - CNT_W'(1);
                    if (c_fill_next >= i_w) begin
                        r_j     <= '0;
                        r_acc   <= '0;
                        r_state <= B_MAC;
                    end else if (r_left == CNT_W'(1)) begin
                        if (r_last) begin
                            r_fill <= '0;
                        end
                        r_state <= B_IDLE;
                    end
                end
                B_MAC: begin
                    r_rd_v <= 1'b1;
                    r_j    <= r_j + WW'(1);
                    if (r_j == i_w - WW'(1)) begin
                        r_state <= B_DRAIN;
                    end
                end
                B_DRAIN: begin
                    if (!r_rd_v && !r_mul_v) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: begin
                    if (!r_out_valid || i_m_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_acc;
                        r_out_last  <= r_last && (r_left == '0);
                        if (r_left == '0) begin
                            if (r_last) begin
                                r_fill <= '0;
                            end
                            r_state <= B_IDLE;
                        end else begin
                            r_state <= B_PUSH;
                        end
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    a_push_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_PUSH) |-> (r_left != '0))
        else $error("push step with no pushes left");

    a_fill_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_TAPS)
        else $error("fill level beyond window depth");

    a_out_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_OUT) |-> (!r_rd_v && !r_mul_v))
        else $error("result taken before accumulation finished");

    a_rd_from_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> ($past(r_state) == B_MAC))
        else $error("tap read issued outside accumulation");

endmodule

// ===== rtl/fir_filter_edge_replicate_core.sv =====
// Top level of the edge-replicating FIR filter.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tdata: tap_index, value; tuser: action;
//                                                tlast: last
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: filtered; tlast: last_out
//  cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_data: tap_count
//
//  A tap load is written while the back part is idle. A sample expands into its pushes;
//  a push that leaves the window short yields no result, and one that yields a result
//  walks the single multiply-accumulate over the W taps.
//  A two-entry queue lets the front take requests while the back works.
//  Reset is synchronous, active low; tap and delay memories are not cleared.
//  A held result stalls the back at its next result, then the queue fills and blocks input.
`timescale 1ns / 1ps
module fir_filter_edge_replicate_core #(
    parameter int MAX_TAPS   = fir_er_pkg::MAX_TAPS_DEF,
    parameter int DATA_WIDTH = fir_er_pkg::DATA_WIDTH_DEF,
    localparam int IN_TDATA_W = ((fir_er_pkg::IDX_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fir_er_pkg::TC_W-1:0]        i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,   // tap_index, value
    input  logic                               s_axis_tuser,   // action
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [fir_er_pkg::OUT_TDATA_W-1:0] m_axis_tdata,   // filtered
    output logic                               m_axis_tlast
);
    import fir_er_pkg::*;

    localparam int WW  = $clog2(MAX_TAPS + 1);
    localparam int Q_W = $bits(t_cmd) + DATA_WIDTH;

    logic [TC_W-1:0]       r_tap_count;
    logic [WW-1:0]         c_w;
    logic                  c_f_valid;
    logic                  c_f_ready;
    t_cmd                  c_f_cmd;
    logic [DATA_WIDTH-1:0] c_f_value;
    logic                  c_b_valid;
    logic                  c_b_ready;
    logic [Q_W-1:0]        c_q_out;
    t_cmd                  c_b_cmd;
    logic [DATA_WIDTH-1:0] c_b_value;
    logic [OUT_W-1:0]      c_m_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TC_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_tap_count <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_tap_count == '0) begin
            c_w = WW'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            c_w = WW'(MAX_TAPS);
        end else begin
            c_w = WW'(r_tap_count);
        end
    end

    fir_er_front #(
        .MAX_TAPS   (MAX_TAPS),
        .DATA_WIDTH (DATA_WIDTH),
        .WW         (WW),
        .IN_TDATA_W (IN_TDATA_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_w           (c_w),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_cmd_valid   (c_f_valid),
        .i_cmd_ready   (c_f_ready),
        .o_cmd         (c_f_cmd),
        .o_cmd_value   (c_f_value)
    );

    fir_er_fifo #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_f_valid),
        .o_ready (c_f_ready),
        .i_data  ({c_f_value, c_f_cmd}),
        .o_valid (c_b_valid),
        .i_ready (c_b_ready),
        .o_data  (c_q_out)
    );

    assign c_b_cmd   = c_q_out[$bits(t_cmd)-1:0];
    assign c_b_value = c_q_out[Q_W-1:$bits(t_cmd)];

    fir_er_back #(
        .MAX_TAPS   (MAX_TAPS),
        .DATA_WIDTH (DATA_WIDTH),
        .WW         (WW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_w         (c_w),
        .i_cmd_valid (c_b_valid),
        .o_cmd_ready (c_b_ready),
        .i_cmd       (c_b_cmd),
        .i_cmd_value (c_b_value),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (c_m_data),
        .o_m_last    (m_axis_tlast)
    );

    assign m_axis_tdata = OUT_TDATA_W'(c_m_data);

endmodule
